// ===== hw/rtl/asr_pkg.sv =====
// shared types, constants and the step program of the advection residual block
`default_nettype none

package asr_pkg;

  localparam int DATA_W            = 32;
  localparam int FRAC_BITS_DEFAULT = 16;
  localparam int RF_DEPTH          = 16;

  // configuration register indexes
  localparam logic CFG_SCHEME    = 1'b0;
  localparam logic CFG_TIME_STEP = 1'b1;

  // scheme codes
  localparam logic [2:0] SCHEME_NONE   = 3'd0;
  localparam logic [2:0] SCHEME_UPWIND = 3'd1;
  localparam logic [2:0] SCHEME_SOU    = 3'd2;
  localparam logic [2:0] SCHEME_FROMM  = 3'd3;
  localparam logic [2:0] SCHEME_MINMOD = 3'd4;

  typedef struct packed {
    logic              axis;
    logic signed [31:0] value_far_low;
    logic signed [31:0] value_low;
    logic signed [31:0] value_center;
    logic signed [31:0] value_high;
    logic signed [31:0] value_far_high;
    logic signed [31:0] vel_low_face;
    logic signed [31:0] vel_high_face;
    logic [30:0]        spacing_low;
    logic [30:0]        spacing_high;
    logic [30:0]        spacing_cell;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] residual;
    logic               error_flag;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_NEG, OP_ABS, OP_SCL3, OP_SCL5, OP_HALF, OP_EIGHTH,
    OP_MINMOD, OP_MUL, OP_DIV, OP_FIN
  } op_t;

  // operand codes: scratch registers below 16; item fields, time step and zero from 16 up
  localparam logic [4:0] T0  = 5'd0;
  localparam logic [4:0] T1  = 5'd1;
  localparam logic [4:0] T2  = 5'd2;
  localparam logic [4:0] T3  = 5'd3;
  localparam logic [4:0] T4  = 5'd4;
  localparam logic [4:0] T5  = 5'd5;
  localparam logic [4:0] T6  = 5'd6;
  localparam logic [4:0] T7  = 5'd7;
  localparam logic [4:0] T8  = 5'd8;
  localparam logic [4:0] T9  = 5'd9;
  localparam logic [4:0] T10 = 5'd10;
  localparam logic [4:0] T11 = 5'd11;
  localparam logic [4:0] T12 = 5'd12;
  localparam logic [4:0] SRC_A    = 5'd16;
  localparam logic [4:0] SRC_B    = 5'd17;
  localparam logic [4:0] SRC_C    = 5'd18;
  localparam logic [4:0] SRC_D    = 5'd19;
  localparam logic [4:0] SRC_E    = 5'd20;
  localparam logic [4:0] SRC_VL   = 5'd21;
  localparam logic [4:0] SRC_VH   = 5'd22;
  localparam logic [4:0] SRC_SL   = 5'd23;
  localparam logic [4:0] SRC_SH   = 5'd24;
  localparam logic [4:0] SRC_SC   = 5'd25;
  localparam logic [4:0] SRC_DT   = 5'd26;
  localparam logic [4:0] SRC_ZERO = 5'd27;

  typedef struct packed {
    op_t        op;
    logic [3:0] dst;
    logic [4:0] src_a;
    logic [4:0] src_b;
  } uop_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic exec;
    logic mul_wr;
    logic div_wr;
    uop_t uop;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic fin_block;
  } dp_status_t;

  // {overflow, value} clamped to the signed 32-bit range
  function automatic logic [32:0] sat_wide(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return {1'b1, 32'h7fff_ffff};
    end else if (x < -64'sd2147483648) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, x[31:0]};
  endfunction

  function automatic uop_t mk(input op_t op, input logic [4:0] d, input logic [4:0] a,
                              input logic [4:0] b);
    return '{op, d[3:0], a, b};
  endfunction

  // step program per scheme; every program ends in OP_FIN
  function automatic uop_t ucode(input logic [2:0] prog, input logic [5:0] step);
    uop_t u;
    u = mk(OP_FIN, T0, SRC_ZERO, SRC_ZERO);
    case (prog)
      SCHEME_UPWIND: begin
        case (step)
          6'd0:  u = mk(OP_ADD,  T0, SRC_C, SRC_B);
          6'd1:  u = mk(OP_MUL,  T0, SRC_VL, T0);
          6'd2:  u = mk(OP_HALF, T0, T0, SRC_ZERO);
          6'd3:  u = mk(OP_ABS,  T1, SRC_VL, SRC_ZERO);
          6'd4:  u = mk(OP_SUB,  T2, SRC_C, SRC_B);
          6'd5:  u = mk(OP_MUL,  T1, T1, T2);
          6'd6:  u = mk(OP_HALF, T1, T1, SRC_ZERO);
          6'd7:  u = mk(OP_SUB,  T0, T0, T1);
          6'd8:  u = mk(OP_ADD,  T1, SRC_D, SRC_C);
          6'd9:  u = mk(OP_MUL,  T1, SRC_VH, T1);
          6'd10: u = mk(OP_HALF, T1, T1, SRC_ZERO);
          6'd11: u = mk(OP_ABS,  T2, SRC_VH, SRC_ZERO);
          6'd12: u = mk(OP_SUB,  T3, SRC_D, SRC_C);
          6'd13: u = mk(OP_MUL,  T2, T2, T3);
          6'd14: u = mk(OP_HALF, T2, T2, SRC_ZERO);
          6'd15: u = mk(OP_SUB,  T1, T1, T2);
          6'd16: u = mk(OP_SUB,  T0, T1, T0);
          6'd17: u = mk(OP_DIV,  T0, T0, SRC_SC);
          default: u = mk(OP_FIN, T0, T0, SRC_ZERO);
        endcase
      end
      SCHEME_SOU: begin
        case (step)
          6'd0:  u = mk(OP_SCL3, T4, SRC_B, SRC_ZERO);
          6'd1:  u = mk(OP_SUB,  T4, T4, SRC_A);
          6'd2:  u = mk(OP_HALF, T4, T4, SRC_ZERO);
          6'd3:  u = mk(OP_SCL3, T5, SRC_C, SRC_ZERO);
          6'd4:  u = mk(OP_SUB,  T5, T5, SRC_D);
          6'd5:  u = mk(OP_HALF, T5, T5, SRC_ZERO);
          6'd6:  u = mk(OP_SCL3, T6, SRC_C, SRC_ZERO);
          6'd7:  u = mk(OP_SUB,  T6, T6, SRC_B);
          6'd8:  u = mk(OP_HALF, T6, T6, SRC_ZERO);
          6'd9:  u = mk(OP_SCL3, T7, SRC_D, SRC_ZERO);
          6'd10: u = mk(OP_SUB,  T7, T7, SRC_E);
          6'd11: u = mk(OP_HALF, T7, T7, SRC_ZERO);
          6'd12: u = mk(OP_ADD,  T0, T5, T4);
          6'd13: u = mk(OP_MUL,  T0, SRC_VL, T0);
          6'd14: u = mk(OP_HALF, T0, T0, SRC_ZERO);
          6'd15: u = mk(OP_ABS,  T1, SRC_VL, SRC_ZERO);
          6'd16: u = mk(OP_SUB,  T2, T5, T4);
          6'd17: u = mk(OP_MUL,  T1, T1, T2);
          6'd18: u = mk(OP_HALF, T1, T1, SRC_ZERO);
          6'd19: u = mk(OP_SUB,  T0, T0, T1);
          6'd20: u = mk(OP_ADD,  T1, T7, T6);
          6'd21: u = mk(OP_MUL,  T1, SRC_VH, T1);
          6'd22: u = mk(OP_HALF, T1, T1, SRC_ZERO);
          6'd23: u = mk(OP_ABS,  T2, SRC_VH, SRC_ZERO);
          6'd24: u = mk(OP_SUB,  T3, T7, T6);
          6'd25: u = mk(OP_MUL,  T2, T2, T3);
          6'd26: u = mk(OP_HALF, T2, T2, SRC_ZERO);
          6'd27: u = mk(OP_SUB,  T1, T1, T2);
          6'd28: u = mk(OP_SUB,  T0, T1, T0);
          6'd29: u = mk(OP_DIV,  T0, T0, SRC_SC);
          default: u = mk(OP_FIN, T0, T0, SRC_ZERO);
        endcase
      end
      SCHEME_FROMM: begin
        case (step)
          6'd0:  u = mk(OP_ADD,    T2, SRC_C, SRC_B);
          6'd1:  u = mk(OP_SCL5,   T2, T2, SRC_ZERO);
          6'd2:  u = mk(OP_SUB,    T2, T2, SRC_D);
          6'd3:  u = mk(OP_SUB,    T2, T2, SRC_A);
          6'd4:  u = mk(OP_MUL,    T2, SRC_VL, T2);
          6'd5:  u = mk(OP_EIGHTH, T2, T2, SRC_ZERO);
          6'd6:  u = mk(OP_SUB,    T3, SRC_C, SRC_B);
          6'd7:  u = mk(OP_SCL3,   T3, T3, SRC_ZERO);
          6'd8:  u = mk(OP_SUB,    T3, T3, SRC_D);
          6'd9:  u = mk(OP_ADD,    T3, T3, SRC_A);
          6'd10: u = mk(OP_ABS,    T4, SRC_VL, SRC_ZERO);
          6'd11: u = mk(OP_MUL,    T3, T4, T3);
          6'd12: u = mk(OP_EIGHTH, T3, T3, SRC_ZERO);
          6'd13: u = mk(OP_SUB,    T0, T2, T3);
          6'd14: u = mk(OP_ADD,    T2, SRC_D, SRC_C);
          6'd15: u = mk(OP_SCL5,   T2, T2, SRC_ZERO);
          6'd16: u = mk(OP_SUB,    T2, T2, SRC_E);
          6'd17: u = mk(OP_SUB,    T2, T2, SRC_B);
          6'd18: u = mk(OP_MUL,    T2, SRC_VH, T2);
          6'd19: u = mk(OP_EIGHTH, T2, T2, SRC_ZERO);
          6'd20: u = mk(OP_SUB,    T3, SRC_D, SRC_C);
          6'd21: u = mk(OP_SCL3,   T3, T3, SRC_ZERO);
          6'd22: u = mk(OP_SUB,    T3, T3, SRC_E);
          6'd23: u = mk(OP_ADD,    T3, T3, SRC_B);
          6'd24: u = mk(OP_ABS,    T4, SRC_VH, SRC_ZERO);
          6'd25: u = mk(OP_MUL,    T3, T4, T3);
          6'd26: u = mk(OP_EIGHTH, T3, T3, SRC_ZERO);
          6'd27: u = mk(OP_SUB,    T1, T2, T3);
          6'd28: u = mk(OP_SUB,    T0, T1, T0);
          6'd29: u = mk(OP_DIV,    T0, T0, SRC_SC);
          default: u = mk(OP_FIN, T0, T0, SRC_ZERO);
        endcase
      end
      SCHEME_MINMOD: begin
        case (step)
          // limited slopes s2 in T2, s1 in T5, s0 in T6
          6'd0:  u = mk(OP_SUB,    T0, SRC_D, SRC_C);
          6'd1:  u = mk(OP_DIV,    T0, T0, SRC_SH);
          6'd2:  u = mk(OP_SUB,    T1, SRC_E, SRC_D);
          6'd3:  u = mk(OP_DIV,    T1, T1, SRC_SH);
          6'd4:  u = mk(OP_MINMOD, T2, T0, T1);
          6'd5:  u = mk(OP_SUB,    T1, SRC_C, SRC_B);
          6'd6:  u = mk(OP_DIV,    T3, T1, SRC_SL);
          6'd7:  u = mk(OP_DIV,    T4, T1, SRC_SH);
          6'd8:  u = mk(OP_MINMOD, T5, T3, T0);
          6'd9:  u = mk(OP_SUB,    T1, SRC_B, SRC_A);
          6'd10: u = mk(OP_DIV,    T1, T1, SRC_SL);
          6'd11: u = mk(OP_MINMOD, T6, T1, T4);
          6'd12: u = mk(OP_MUL,    T0, SRC_VH, SRC_DT);
          6'd13: u = mk(OP_MUL,    T1, SRC_VL, SRC_DT);
          // reconstruction terms: upper up T3, upper down T4, lower up T7, lower down T8
          6'd14: u = mk(OP_ADD,    T3, SRC_SH, T0);
          6'd15: u = mk(OP_MUL,    T3, T2, T3);
          6'd16: u = mk(OP_HALF,   T3, T3, SRC_ZERO);
          6'd17: u = mk(OP_NEG,    T3, T3, SRC_ZERO);
          6'd18: u = mk(OP_SUB,    T4, SRC_SH, T0);
          6'd19: u = mk(OP_MUL,    T4, T5, T4);
          6'd20: u = mk(OP_HALF,   T4, T4, SRC_ZERO);
          6'd21: u = mk(OP_ADD,    T7, SRC_SL, T1);
          6'd22: u = mk(OP_MUL,    T7, T5, T7);
          6'd23: u = mk(OP_HALF,   T7, T7, SRC_ZERO);
          6'd24: u = mk(OP_NEG,    T7, T7, SRC_ZERO);
          6'd25: u = mk(OP_SUB,    T8, SRC_SL, T1);
          6'd26: u = mk(OP_MUL,    T8, T6, T8);
          6'd27: u = mk(OP_HALF,   T8, T8, SRC_ZERO);
          // lower face flux into T9
          6'd28: u = mk(OP_ADD,    T9, SRC_C, SRC_B);
          6'd29: u = mk(OP_ADD,    T9, T9, T7);
          6'd30: u = mk(OP_ADD,    T9, T9, T8);
          6'd31: u = mk(OP_MUL,    T9, SRC_VL, T9);
          6'd32: u = mk(OP_HALF,   T9, T9, SRC_ZERO);
          6'd33: u = mk(OP_SUB,    T10, SRC_C, SRC_B);
          6'd34: u = mk(OP_ADD,    T10, T10, T7);
          6'd35: u = mk(OP_SUB,    T10, T10, T8);
          6'd36: u = mk(OP_ABS,    T11, SRC_VL, SRC_ZERO);
          6'd37: u = mk(OP_MUL,    T10, T11, T10);
          6'd38: u = mk(OP_HALF,   T10, T10, SRC_ZERO);
          6'd39: u = mk(OP_SUB,    T9, T9, T10);
          // upper face flux into T10, symmetric limiter terms
          6'd40: u = mk(OP_ADD,    T10, SRC_D, SRC_C);
          6'd41: u = mk(OP_ADD,    T10, T10, T3);
          6'd42: u = mk(OP_ADD,    T10, T10, T4);
          6'd43: u = mk(OP_MUL,    T10, SRC_VH, T10);
          6'd44: u = mk(OP_HALF,   T10, T10, SRC_ZERO);
          6'd45: u = mk(OP_SUB,    T11, SRC_D, SRC_C);
          6'd46: u = mk(OP_ADD,    T11, T11, T3);
          6'd47: u = mk(OP_SUB,    T11, T11, T4);
          6'd48: u = mk(OP_ABS,    T12, SRC_VH, SRC_ZERO);
          6'd49: u = mk(OP_MUL,    T11, T12, T11);
          6'd50: u = mk(OP_HALF,   T11, T11, SRC_ZERO);
          6'd51: u = mk(OP_SUB,    T10, T10, T11);
          6'd52: u = mk(OP_SUB,    T0, T10, T9);
          6'd53: u = mk(OP_DIV,    T0, T0, SRC_SC);
          default: u = mk(OP_FIN, T0, T0, SRC_ZERO);
        endcase
      end
      default: u = mk(OP_FIN, T0, SRC_ZERO, SRC_ZERO);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/asr_ram.sv =====
// generic register file memory, one write port and two registered read ports
`default_nettype none

module asr_ram #(
  parameter int WIDTH = asr_pkg::DATA_W,
  parameter int DEPTH = asr_pkg::RF_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/asr_ctrl.sv =====
// sequencer that steps the scheme program and drives the datapath
`default_nettype none

module asr_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  logic [2:0]             scheme,
  input  asr_pkg::dp_status_t    status,
  output asr_pkg::dp_cmd_t       cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_EXEC = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_DIV  = 5'b10000
  } state_t;

  state_t        state, state_next;
  logic [5:0]    step, step_next;
  logic [2:0]    prog, prog_next;
  logic          advance;
  asr_pkg::uop_t uop;

  assign uop = asr_pkg::ucode(prog, step);

  always_comb begin
    state_next = state;
    step_next  = step;
    prog_next  = prog;
    advance    = 1'b0;
    item_ready = 1'b0;
    cmd        = '0;
    cmd.uop    = uop;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load   = 1'b1;
          step_next  = '0;
          prog_next  = scheme;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.issue  = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        // a finished cell waits until the output register is free
        if (!(uop.op == asr_pkg::OP_FIN && status.fin_block)) begin
          cmd.exec = 1'b1;
          if (uop.op == asr_pkg::OP_MUL) begin
            state_next = ST_MUL;
          end else if (uop.op == asr_pkg::OP_DIV) begin
            state_next = ST_DIV;
          end else begin
            advance = 1'b1;
          end
        end
      end
      ST_MUL: begin
        cmd.mul_wr = 1'b1;
        advance    = 1'b1;
      end
      ST_DIV: begin
        if (status.div_done) begin
          cmd.div_wr = 1'b1;
          advance    = 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    if (advance) begin
      if (uop.op == asr_pkg::OP_FIN) begin
        state_next = ST_IDLE;
      end else begin
        step_next  = step + 6'd1;
        state_next = ST_READ;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
      prog  <= asr_pkg::SCHEME_NONE;
    end else begin
      state <= state_next;
      step  <= step_next;
      prog  <= prog_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/asr_datapath.sv =====
// operand store, alu, shared multiplier and divider, partial and result registers
`default_nettype none

module asr_datapath #(
  parameter int FRAC_BITS = asr_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  asr_pkg::dp_cmd_t     cmd,
  output asr_pkg::dp_status_t  status,
  input  asr_pkg::in_item_t    item,
  input  logic [30:0]          time_step,
  output logic                 result_valid,
  input  logic                 result_ready,
  output asr_pkg::out_item_t   result
);

  localparam int DW = asr_pkg::DATA_W + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);

  asr_pkg::in_item_t  hold;
  asr_pkg::uop_t      uop_q;
  logic [31:0]        rdata_a, rdata_b;
  logic signed [31:0] op_a, op_b, fix_a, fix_b;
  logic signed [63:0] aw, bw, pw, abs_a, abs_b;
  logic [32:0]        alu_res, mul_res, div_res, fin_res;
  logic signed [31:0] mm_val;
  logic signed [63:0] prod;
  logic               we, wflag;
  logic [31:0]        wdata;
  logic signed [31:0] partial;
  logic               perr, err;

  // divider
  logic          div_busy, div_neg, div_zero;
  logic [CW-1:0] div_cnt;
  logic [DW-1:0] div_dvd, div_quo;
  logic [31:0]   div_rem, div_nb, na, nb;
  logic [32:0]   div_trial;
  logic signed [63:0] div_q64;

  function automatic logic signed [31:0] fixed_src(input logic [4:0] s,
                                                   input asr_pkg::in_item_t h,
                                                   input logic [30:0] dt);
    logic signed [31:0] v;
    case (s)
      asr_pkg::SRC_A:  v = h.value_far_low;
      asr_pkg::SRC_B:  v = h.value_low;
      asr_pkg::SRC_C:  v = h.value_center;
      asr_pkg::SRC_D:  v = h.value_high;
      asr_pkg::SRC_E:  v = h.value_far_high;
      asr_pkg::SRC_VL: v = h.vel_low_face;
      asr_pkg::SRC_VH: v = h.vel_high_face;
      asr_pkg::SRC_SL: v = {1'b0, h.spacing_low};
      asr_pkg::SRC_SH: v = {1'b0, h.spacing_high};
      asr_pkg::SRC_SC: v = {1'b0, h.spacing_cell};
      asr_pkg::SRC_DT: v = {1'b0, dt};
      default:         v = '0;
    endcase
    return v;
  endfunction

  asr_ram #(
    .WIDTH(asr_pkg::DATA_W),
    .DEPTH(asr_pkg::RF_DEPTH)
  ) u_rf (
    .clk    (clk),
    .we     (we),
    .waddr  (uop_q.dst),
    .wdata  (wdata),
    .re     (cmd.issue),
    .raddr_a(cmd.uop.src_a[3:0]),
    .raddr_b(cmd.uop.src_b[3:0]),
    .rdata_a(rdata_a),
    .rdata_b(rdata_b)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hold <= item;
    end
    if (cmd.issue) begin
      uop_q <= cmd.uop;
    end
  end

  assign fix_a = fixed_src(uop_q.src_a, hold, time_step);
  assign fix_b = fixed_src(uop_q.src_b, hold, time_step);
  assign op_a  = uop_q.src_a[4] ? fix_a : rdata_a;
  assign op_b  = uop_q.src_b[4] ? fix_b : rdata_b;
  assign aw    = {{32{op_a[31]}}, op_a};
  assign bw    = {{32{op_b[31]}}, op_b};
  assign pw    = {{32{partial[31]}}, partial};
  assign abs_a = op_a[31] ? -aw : aw;
  assign abs_b = op_b[31] ? -bw : bw;

  // minmod: smaller magnitude when signs agree, second slope on a tie
  always_comb begin
    mm_val = '0;
    if ((op_a > 32'sd0 && op_b > 32'sd0) || (op_a < 32'sd0 && op_b < 32'sd0)) begin
      mm_val = (abs_a < abs_b) ? op_a : op_b;
    end
  end

  always_comb begin
    case (uop_q.op)
      asr_pkg::OP_ADD:    alu_res = asr_pkg::sat_wide(aw + bw);
      asr_pkg::OP_SUB:    alu_res = asr_pkg::sat_wide(aw - bw);
      asr_pkg::OP_NEG:    alu_res = asr_pkg::sat_wide(-aw);
      asr_pkg::OP_ABS:    alu_res = asr_pkg::sat_wide(abs_a);
      asr_pkg::OP_SCL3:   alu_res = asr_pkg::sat_wide((aw <<< 1) + aw);
      asr_pkg::OP_SCL5:   alu_res = asr_pkg::sat_wide((aw <<< 2) + aw);
      asr_pkg::OP_HALF:   alu_res = asr_pkg::sat_wide(aw >>> 1);
      asr_pkg::OP_EIGHTH: alu_res = asr_pkg::sat_wide(aw >>> 3);
      asr_pkg::OP_MINMOD: alu_res = {1'b0, mm_val};
      default:            alu_res = '0;
    endcase
  end

  // multiply into a product register, then floor shift and clamp the registered product
  always_ff @(posedge clk) begin
    if (cmd.exec && uop_q.op == asr_pkg::OP_MUL) begin
      prod <= op_a * op_b;
    end
  end
  assign mul_res = asr_pkg::sat_wide(prod >>> FRAC_BITS);

  // restoring divider on magnitudes, one quotient bit a cycle
  assign na        = op_a[31] ? (~op_a + 32'd1) : op_a;
  assign nb        = op_b[31] ? (~op_b + 32'd1) : op_b;
  assign div_trial = {div_rem, div_dvd[DW-1]};
  assign div_q64   = {{(64 - DW){1'b0}}, div_quo};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_cnt  <= '0;
    end else if (cmd.exec && uop_q.op == asr_pkg::OP_DIV) begin
      div_busy <= 1'b1;
      div_zero <= (op_b == 32'sd0);
      div_neg  <= op_a[31] ^ op_b[31];
      div_nb   <= nb;
      div_dvd  <= {na, {FRAC_BITS{1'b0}}};
      div_rem  <= '0;
      div_quo  <= '0;
      div_cnt  <= (op_b == 32'sd0) ? '0 : CW'(DW);
    end else if (cmd.div_wr) begin
      div_busy <= 1'b0;
    end else if (div_busy && div_cnt != '0) begin
      if (div_trial >= {1'b0, div_nb}) begin
        div_rem <= 32'(div_trial - {1'b0, div_nb});
        div_quo <= {div_quo[DW-2:0], 1'b1};
      end else begin
        div_rem <= div_trial[31:0];
        div_quo <= {div_quo[DW-2:0], 1'b0};
      end
      div_dvd <= {div_dvd[DW-2:0], 1'b0};
      div_cnt <= div_cnt - CW'(1);
    end
  end

  always_comb begin
    if (div_zero) begin
      div_res = {1'b1, 32'd0};
    end else if (div_neg) begin
      div_res = asr_pkg::sat_wide(-div_q64);
    end else begin
      div_res = asr_pkg::sat_wide(div_q64);
    end
  end

  always_comb begin
    we    = 1'b0;
    wdata = alu_res[31:0];
    wflag = 1'b0;
    if (cmd.mul_wr) begin
      we    = 1'b1;
      wdata = mul_res[31:0];
      wflag = mul_res[32];
    end else if (cmd.div_wr) begin
      we    = 1'b1;
      wdata = div_res[31:0];
      wflag = div_res[32];
    end else if (cmd.exec && uop_q.op != asr_pkg::OP_MUL && uop_q.op != asr_pkg::OP_DIV
                 && uop_q.op != asr_pkg::OP_FIN) begin
      we    = 1'b1;
      wflag = alu_res[32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      err <= 1'b0;
    end else if (cmd.load) begin
      err <= 1'b0;
    end else if (we && wflag) begin
      err <= 1'b1;
    end
  end

  assign fin_res = asr_pkg::sat_wide(pw + aw);

  always_ff @(posedge clk) begin
    if (rst) begin
      partial      <= '0;
      perr         <= 1'b0;
      result_valid <= 1'b0;
    end else if (cmd.exec && uop_q.op == asr_pkg::OP_FIN) begin
      if (!hold.axis) begin
        partial <= op_a;
        perr    <= err;
        // a waiting result may leave in the same cycle
        if (result_ready) begin
          result_valid <= 1'b0;
        end
      end else begin
        result.residual   <= fin_res[31:0];
        result.error_flag <= err | perr | fin_res[32];
        result_valid      <= 1'b1;
        partial           <= '0;
        perr              <= 1'b0;
      end
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  assign status.div_done  = div_busy && (div_cnt == '0);
  assign status.fin_block = hold.axis && result_valid;

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(cmd.exec && uop_q.op == asr_pkg::OP_FIN && hold.axis))
    else $error("result raised without a completing vertical item");

  a_div_quiet: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> !(cmd.exec || cmd.issue || cmd.load))
    else $error("sequencer moved on while the divider was busy");

  a_partial_cleared: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && uop_q.op == asr_pkg::OP_FIN && hold.axis) |=> (partial == '0 && !perr))
    else $error("stored horizontal part not cleared after vertical item");

endmodule

`default_nettype wire

// ===== hw/rtl/advection_stencil_residual_top.sv =====
// top level of the advection residual block: configuration registers, sequencer, datapath
// each step passes through the read and execute states; a multiply adds the product write
// state of the one shared multiplier, and a divide waits in the divide state on the
// bit-serial divider; values are Q16.16 at the default FRAC_BITS; a divide by a zero
// spacing skips the serial division; a vertical item also waits while the previous result
// is held; throughput: one item at a time, taken when idle
// reset: synchronous, clears control, stored part and both registers, no clearing pass
`default_nettype none

module advection_stencil_residual_top #(
  parameter int FRAC_BITS = asr_pkg::FRAC_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  asr_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_ready,
  output asr_pkg::out_item_t result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [30:0]        cfg_data
);

  logic [2:0]          scheme;
  logic [30:0]         time_step;
  asr_pkg::dp_cmd_t    cmd;
  asr_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scheme    <= asr_pkg::SCHEME_NONE;
      time_step <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        asr_pkg::CFG_SCHEME:    scheme    <= cfg_data[2:0];
        asr_pkg::CFG_TIME_STEP: time_step <= cfg_data;
      endcase
    end
  end

  asr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .scheme    (scheme),
    .status    (status),
    .cmd       (cmd)
  );

  asr_datapath #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .item        (item),
    .time_step   (time_step),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// self-checking testbench of the advection stencil residual block
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 16;
  localparam int WATCHDOG = 200000;
  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;

  logic clk, rst;
  logic item_valid, item_ready, result_valid, result_ready;
  asr_pkg::in_item_t item;
  asr_pkg::out_item_t result;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [30:0] cfg_data;

  advection_stencil_residual_top uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // predictor state
  logic [2:0]  pr_scheme;
  logic [30:0] pr_dt;
  longint      pr_part;
  bit          pr_perr;
  bit          sat_hit;

  asr_pkg::out_item_t residual_q[$];
  int errors;
  int idle_cycles;
  bit hold_off;

  function automatic longint sat(longint x);
    if (x > QMAX) begin sat_hit = 1; return QMAX; end
    if (x < QMIN) begin sat_hit = 1; return QMIN; end
    return x;
  endfunction
  function automatic longint fshr(longint x, int n);
    return x >>> n;
  endfunction
  function automatic longint qadd(longint a, longint b); return sat(a + b); endfunction
  function automatic longint qsub(longint a, longint b); return sat(a - b); endfunction
  function automatic longint qabs(longint a); return sat(a < 0 ? -a : a); endfunction
  function automatic longint qmul(longint a, longint b); return sat(fshr(a * b, FB)); endfunction
  function automatic longint qdiv(longint a, longint b);
    if (b == 0) begin sat_hit = 1; return 0; end
    return sat((a * (64'sd1 <<< FB)) / b);
  endfunction
  function automatic longint mmod(longint a, longint b);
    longint aa, ab;
    if ((a > 0 && b > 0) || (a < 0 && b < 0)) begin
      aa = a < 0 ? -a : a;
      ab = b < 0 ? -b : b;
      return aa < ab ? a : b;
    end
    return 0;
  endfunction
  function automatic longint flux(longint v, longint fd, longint fu);
    longint p, m;
    p = fshr(qmul(v, qadd(fu, fd)), 1);
    m = fshr(qmul(qabs(v), qsub(fu, fd)), 1);
    return qsub(p, m);
  endfunction
  function automatic longint sou(longint x, longint y);
    return fshr(qsub(sat(x * 3), y), 1);
  endfunction
  function automatic longint fromm(longint v, longint ff, longint f, longint g, longint gg);
    longint s, t;
    s = qsub(qsub(sat(qadd(g, f) * 5), gg), ff);
    t = qadd(qsub(sat(qsub(g, f) * 3), gg), ff);
    return qsub(fshr(qmul(v, s), 3), fshr(qmul(qabs(v), t), 3));
  endfunction
  function automatic longint limited(longint v, longint f, longint g, longint lu, longint ld);
    longint s, t;
    s = qadd(qadd(qadd(g, f), lu), ld);
    t = qsub(qadd(qsub(g, f), lu), ld);
    return qsub(fshr(qmul(v, s), 1), fshr(qmul(qabs(v), t), 1));
  endfunction

  function automatic longint axis_residual(asr_pkg::in_item_t it);
    longint a, b, c, d, e, vl, vh, sl, sh, sc, fl, fh, s0, s1, s2, vhdt, vldt;
    longint lhu, lhd, llu, lld, dt;
    a = it.value_far_low; b = it.value_low; c = it.value_center;
    d = it.value_high; e = it.value_far_high;
    vl = it.vel_low_face; vh = it.vel_high_face;
    sl = {33'd0, it.spacing_low}; sh = {33'd0, it.spacing_high};
    sc = {33'd0, it.spacing_cell}; dt = {33'd0, pr_dt};
    case (pr_scheme)
      asr_pkg::SCHEME_UPWIND: begin
        fl = flux(vl, b, c);
        fh = flux(vh, c, d);
      end
      asr_pkg::SCHEME_SOU: begin
        fl = flux(vl, sou(b, a), sou(c, d));
        fh = flux(vh, sou(c, b), sou(d, e));
      end
      asr_pkg::SCHEME_FROMM: begin
        fl = fromm(vl, a, b, c, d);
        fh = fromm(vh, b, c, d, e);
      end
      asr_pkg::SCHEME_MINMOD: begin
        s2 = mmod(qdiv(qsub(d, c), sh), qdiv(qsub(e, d), sh));
        s1 = mmod(qdiv(qsub(c, b), sl), qdiv(qsub(d, c), sh));
        s0 = mmod(qdiv(qsub(b, a), sl), qdiv(qsub(c, b), sh));
        vhdt = qmul(vh, dt);
        vldt = qmul(vl, dt);
        lhu = sat(-fshr(qmul(s2, qadd(sh, vhdt)), 1));
        lhd = fshr(qmul(s1, qsub(sh, vhdt)), 1);
        llu = sat(-fshr(qmul(s1, qadd(sl, vldt)), 1));
        lld = fshr(qmul(s0, qsub(sl, vldt)), 1);
        fl = limited(vl, b, c, llu, lld);
        fh = limited(vh, c, d, lhu, lhd);
      end
      default: return 0;
    endcase
    return qdiv(qsub(fh, fl), sc);
  endfunction

  // returns 1 when the item completes a cell
  function automatic bit predict_cell(asr_pkg::in_item_t it, output asr_pkg::out_item_t r);
    longint p;
    sat_hit = 0;
    p = axis_residual(it);
    r = '0;
    if (!it.axis) begin
      pr_part = p;
      pr_perr = sat_hit;
      return 0;
    end
    p = qadd(pr_part, p);
    r.residual = p[31:0];
    r.error_flag = sat_hit | pr_perr;
    pr_part = 0;
    pr_perr = 0;
    return 1;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // input side idles only when the gap is not empty
  task automatic gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n != 0) item_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // result side: random stall plus one long hold-off
  always @(posedge clk) begin
    if (rst) result_ready <= 1'b0;
    else if (hold_off) result_ready <= 1'b0;
    else result_ready <= ($urandom_range(0, 9) == 0) ? 1'b0 : ($urandom_range(0, 4) != 0);
  end

  always @(posedge clk) begin
    asr_pkg::out_item_t w;
    if (!rst && result_valid && result_ready) begin
      if (residual_q.size() == 0) begin
        report("unexpected result", result.residual, 32'd0);
      end else begin
        w = residual_q.pop_front();
        if (result.residual !== w.residual) report("residual", result.residual, w.residual);
        if (result.error_flag !== w.error_flag)
          report("error_flag", 32'(result.error_flag), 32'(w.error_flag));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)
        || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [30:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == asr_pkg::CFG_SCHEME) pr_scheme = val[2:0];
    else pr_dt = val;
    @(posedge clk);
  endtask

  // valid stays up after the accepting edge until gap, drain or the next item
  task automatic send(asr_pkg::in_item_t it);
    asr_pkg::out_item_t r;
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
    if (predict_cell(it, r)) residual_q.push_back(r);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (residual_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  function automatic logic [31:0] rval(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      default: return 32'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
    endcase
  endfunction
  function automatic logic [30:0] rspace(int mode);
    if ($urandom_range(0, 30) == 0) return 31'd0;
    if (mode == 0) return 31'($urandom());
    return 31'($urandom_range(1 << 14, 4 << 16));
  endfunction

  function automatic asr_pkg::in_item_t rand_item(bit ax);
    asr_pkg::in_item_t it;
    int m;
    m = $urandom_range(0, 5) == 0 ? 0 : $urandom_range(1, 2);
    it.axis = ax;
    it.value_far_low = rval(m); it.value_low = rval(m); it.value_center = rval(m);
    it.value_high = rval(m); it.value_far_high = rval(m);
    it.vel_low_face = rval(m); it.vel_high_face = rval(m);
    it.spacing_low = rspace(m); it.spacing_high = rspace(m); it.spacing_cell = rspace(m);
    return it;
  endfunction

  function automatic asr_pkg::in_item_t fill(bit ax, logic [31:0] v, logic [31:0] w,
                                             logic [30:0] s);
    asr_pkg::in_item_t it;
    it.axis = ax;
    it.value_far_low = v; it.value_low = -v; it.value_center = v;
    it.value_high = w; it.value_far_high = -w;
    it.vel_low_face = w; it.vel_high_face = v;
    it.spacing_low = s; it.spacing_high = s; it.spacing_cell = s;
    return it;
  endfunction

  typedef struct {
    asr_pkg::in_item_t  it;
    bit                 known;
    asr_pkg::out_item_t want;
  } row_t;

  row_t rows[$];
  localparam logic [2:0] SCHEMES[6] = '{asr_pkg::SCHEME_NONE, asr_pkg::SCHEME_UPWIND,
                                         asr_pkg::SCHEME_SOU, asr_pkg::SCHEME_FROMM,
                                         asr_pkg::SCHEME_MINMOD, 3'd7};

  initial begin
    asr_pkg::out_item_t r;
    row_t row;
    int n;
    errors = 0;
    hold_off = 0;
    pr_scheme = asr_pkg::SCHEME_NONE; pr_dt = '0; pr_part = 0; pr_perr = 0;
    item_valid = 0; item = '0; cfg_valid = 0; cfg_index = asr_pkg::CFG_SCHEME; cfg_data = '0;
    rst = 1;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed table, scheme none after reset: every vertical gives zero, no error
    row.it = fill(1, 32'h7fffffff, 32'h80000000, 31'd0);
    row.known = 1; row.want = '{32'sd0, 1'b0}; rows.push_back(row);
    row.it = fill(0, 32'h80000000, 32'h7fffffff, 31'h7fffffff);
    row.known = 0; rows.push_back(row);
    row.it = fill(1, 32'h00010000, 32'hffff0000, 31'h10000);
    row.known = 1; row.want = '{32'sd0, 1'b0}; rows.push_back(row);
    foreach (rows[i]) begin
      send(rows[i].it);
      if (rows[i].known && rows[i].it.axis) begin
        r = residual_q[$];
        if (r !== rows[i].want) report("table", r.residual, rows[i].want.residual);
      end
    end
    drain();
    // each scheme: zero spacing, extremes, lone vertical, two horizontals
    foreach (SCHEMES[k]) begin
      write_reg(asr_pkg::CFG_SCHEME, {28'd0, SCHEMES[k]});
      write_reg(asr_pkg::CFG_TIME_STEP, k[0] ? 31'h7fffffff : 31'h8000);
      send(fill(1, 32'h00020000, 32'h00010000, 31'd0));
      send(fill(0, 32'h7fffffff, 32'h80000000, 31'h10000));
      send(fill(0, 32'h00030000, 32'hfffe0000, 31'h10000));
      send(fill(1, 32'h80000000, 32'h7fffffff, 31'h7fffffff));
      drain();
    end

    // random phases; one long receiver hold-off in the first
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(asr_pkg::CFG_SCHEME,
                ph < 10 ? {28'd0, SCHEMES[ph % 5]} : 31'($urandom_range(0, 7)));
      write_reg(asr_pkg::CFG_TIME_STEP, ph % 3 == 0 ? 31'd0 :
                ph % 3 == 1 ? 31'h7fffffff : 31'($urandom_range(0, 1 << 17)));
      n = (pr_scheme == asr_pkg::SCHEME_MINMOD) ? 40 : 80;
      for (int j = 0; j < n; j++) begin
        if (ph == 0 && j == 10) fork
          begin
            hold_off <= 1'b1;
            repeat (3000) @(posedge clk);
            hold_off <= 1'b0;
          end
        join_none
        if ($urandom_range(0, 9) == 0) send(rand_item($urandom_range(0, 1)));
        else begin
          send(rand_item(0));
          gap();
          send(rand_item(1));
        end
        gap();
      end
      drain();
    end

    if (errors == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end
endmodule

`default_nettype wire

// ===== advection_stencil_residual_top.f =====
hw/rtl/asr_pkg.sv
hw/rtl/asr_ram.sv
hw/rtl/asr_ctrl.sv
hw/rtl/asr_datapath.sv
hw/rtl/advection_stencil_residual_top.sv
bench/tb_top.sv
